// ===== src/qmm_pkg.sv =====
// Package for the quad motor mixer with pairwise clamping.
// Holds the shared types, register indexes and reset values. No dependencies.
`default_nettype none

package qmm_pkg;

    localparam int TERM_W  = 16;
    localparam int BASE_W  = 10;
    localparam int MOTOR_W = 16;
    localparam int LIM_W   = 10;
    localparam int IDX_W   = 2;

    localparam logic [LIM_W-1:0] UPPER_RST   = 10'd250;
    localparam logic [LIM_W-1:0] TRIGGER_RST = 10'd34;
    localparam logic [LIM_W-1:0] FLOOR_RST   = 10'd35;

    typedef enum logic [IDX_W-1:0] {
        REG_UPPER_LIMIT = 2'd0,
        REG_LOW_TRIGGER = 2'd1,
        REG_LOW_FLOOR   = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [BASE_W-1:0]        base_speed;
        logic signed [TERM_W-1:0] yaw_term;
        logic signed [TERM_W-1:0] roll_term;
        logic signed [TERM_W-1:0] pitch_term;
    } mix_in_t;

    // Element 0 is motor one.
    typedef logic [3:0][MOTOR_W-1:0] motors_t;

    typedef struct packed {
        logic [LIM_W-1:0] upper_limit;
        logic [LIM_W-1:0] low_trigger;
        logic [LIM_W-1:0] low_floor;
    } limits_t;

endpackage

`default_nettype wire

// ===== src/qmm_mix.sv =====
// X-layout mixer: four motor sums in Q.4, truncated toward zero to counts.
// Depends on qmm_pkg.
`default_nettype none

module qmm_mix (
    input  wire qmm_pkg::mix_in_t mix_in,
    output qmm_pkg::motors_t      motors
);

    localparam int SUM_W = 19;

    logic signed [SUM_W-1:0] b_q;
    logic signed [SUM_W-1:0] p_q;
    logic signed [SUM_W-1:0] r_q;
    logic signed [SUM_W-1:0] y_q;
    logic signed [SUM_W-1:0] sum_q [4];

    function automatic logic [qmm_pkg::MOTOR_W-1:0] to_count(logic signed [SUM_W-1:0] q);
        logic signed [SUM_W-1:0] adj;
        logic signed [SUM_W-1:0] w;
        adj = q[SUM_W-1] ? (q + SUM_W'(15)) : q;
        w   = adj >>> 4;
        // |w| stays below 2^14, so it fits int16 and the cut to MOTOR_W bits loses nothing
        return w[qmm_pkg::MOTOR_W-1:0];
    endfunction

    always_comb
    begin
        b_q = $signed({5'b0, mix_in.base_speed, 4'b0});
        p_q = SUM_W'(mix_in.pitch_term);
        r_q = SUM_W'(mix_in.roll_term);
        y_q = SUM_W'(mix_in.yaw_term);
        sum_q[0] = b_q - p_q + r_q + y_q;
        sum_q[1] = b_q + p_q + r_q - y_q;
        sum_q[2] = b_q - p_q - r_q - y_q;
        sum_q[3] = b_q + p_q - r_q + y_q;
        for (int k = 0; k < 4; k++)
        begin
            motors[k] = to_count(sum_q[k]);
        end
    end

endmodule

`default_nettype wire

// ===== src/qmm_clamp.sv =====
// Six pairwise clamp stages: pitch, roll, yaw, each upper then lower.
// Depends on qmm_pkg.
`default_nettype none

module qmm_clamp (
    input  wire qmm_pkg::motors_t motors_in,
    input  wire qmm_pkg::limits_t limits,
    output qmm_pkg::motors_t      motors_out
);

    typedef logic signed [qmm_pkg::MOTOR_W-1:0] cnt_t;

    cnt_t hi;
    cnt_t tr;
    cnt_t fl;

    qmm_pkg::motors_t st [7];

    function automatic qmm_pkg::motors_t upper_stage(qmm_pkg::motors_t m, cnt_t lim,
                                                     logic [1:0] a, logic [1:0] b,
                                                     logic [1:0] c, logic [1:0] d);
        qmm_pkg::motors_t r;
        r = m;
        if ($signed(m[a]) > lim && $signed(m[b]) > lim)
        begin
            r[a] = lim;
            r[b] = lim;
        end
        else if ($signed(m[c]) > lim && $signed(m[d]) > lim)
        begin
            r[c] = lim;
            r[d] = lim;
        end
        return r;
    endfunction

    function automatic qmm_pkg::motors_t lower_stage(qmm_pkg::motors_t m, cnt_t trig,
                                                     cnt_t flr,
                                                     logic [1:0] a, logic [1:0] b,
                                                     logic [1:0] c, logic [1:0] d);
        qmm_pkg::motors_t r;
        r = m;
        if ($signed(m[a]) < trig && $signed(m[b]) < trig)
        begin
            r[a] = flr;
            r[b] = flr;
        end
        else if ($signed(m[c]) < trig && $signed(m[d]) < trig)
        begin
            r[c] = flr;
            r[d] = flr;
        end
        return r;
    endfunction

    always_comb
    begin
        hi = $signed({6'b0, limits.upper_limit});
        tr = $signed({6'b0, limits.low_trigger});
        fl = $signed({6'b0, limits.low_floor});
        st[0] = motors_in;
        st[1] = upper_stage(st[0], hi, 2'd1, 2'd3, 2'd0, 2'd2);
        st[2] = lower_stage(st[1], tr, fl, 2'd1, 2'd3, 2'd0, 2'd2);
        st[3] = upper_stage(st[2], hi, 2'd0, 2'd1, 2'd2, 2'd3);
        st[4] = lower_stage(st[3], tr, fl, 2'd0, 2'd1, 2'd2, 2'd3);
        st[5] = upper_stage(st[4], hi, 2'd0, 2'd3, 2'd1, 2'd2);
        st[6] = lower_stage(st[5], tr, fl, 2'd0, 2'd3, 2'd1, 2'd2);
        motors_out = st[6];
    end

endmodule

`default_nettype wire

// ===== src/quad_motor_mixer_clamp.sv =====
// Top level of the quad motor mixer: input register, mixer, clamp chain,
// result register, limit registers. Depends on qmm_pkg, qmm_mix, qmm_clamp.
//
// channel   direction  handshake                 payload
// s_*       in         s_tvalid / s_tready       s_tdata: pitch, roll, yaw, base
// m_*       out        m_tvalid / m_tready       m_tdata: motor one..four
// cfg_*     in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One transfer per cycle sustained while m_tready stays high; an item passes
// through the input register, then the result register, before m_tvalid rises.
// Reset clears both valid flags and loads the limit defaults.
// A stalled result register holds; the input register still takes one more item.
`default_nettype none

module quad_motor_mixer_clamp (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [63:0] s_tdata,   // pitch_term[15:0], roll_term[31:16], yaw_term[47:32],
                                   // base_speed[57:48], zero[63:58]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [63:0] m_tdata,   // motor_one[15:0], motor_two[31:16],
                                   // motor_three[47:32], motor_four[63:48]
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [9:0]  cfg_data
);

    logic              in_vld_reg;
    logic              in_vld_next;
    qmm_pkg::mix_in_t  in_reg;
    logic              out_vld_reg;
    logic              out_vld_next;
    qmm_pkg::motors_t  out_reg;
    qmm_pkg::limits_t  lim_reg;
    qmm_pkg::limits_t  lim_next;
    qmm_pkg::motors_t  mixed;
    qmm_pkg::motors_t  clamped;
    logic              out_load;
    logic              in_load;

    qmm_mix u_mix (
        .mix_in (in_reg),
        .motors (mixed)
    );

    qmm_clamp u_clamp (
        .motors_in  (mixed),
        .limits     (lim_reg),
        .motors_out (clamped)
    );

    always_comb
    begin
        out_load     = in_vld_reg && (!out_vld_reg || m_tready);
        s_tready     = !in_vld_reg || !out_vld_reg || m_tready;
        in_load      = s_tvalid && s_tready;
        in_vld_next  = in_load || (in_vld_reg && !out_load);
        out_vld_next = out_load || (out_vld_reg && !m_tready);
        m_tvalid     = out_vld_reg;
        m_tdata      = out_reg;
        cfg_ready    = 1'b1;
    end

    always_comb
    begin
        lim_next = lim_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                qmm_pkg::REG_UPPER_LIMIT: lim_next.upper_limit = cfg_data;
                qmm_pkg::REG_LOW_TRIGGER: lim_next.low_trigger = cfg_data;
                qmm_pkg::REG_LOW_FLOOR:   lim_next.low_floor   = cfg_data;
                default:                  lim_next = lim_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg          <= 1'b0;
            out_vld_reg         <= 1'b0;
            lim_reg.upper_limit <= qmm_pkg::UPPER_RST;
            lim_reg.low_trigger <= qmm_pkg::TRIGGER_RST;
            lim_reg.low_floor   <= qmm_pkg::FLOOR_RST;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            lim_reg     <= lim_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_reg <= s_tdata[57:0];
        end
        if (out_load)
        begin
            out_reg <= clamped;
        end
    end

endmodule

`default_nettype wire
